FILE: hw/rtl/sardp_pkg.sv
`default_nettype none

package sardp_pkg;

    localparam int BLOCK_LENGTH_DEF = 512;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam int WEIGHT_W = 8;
    localparam int ACT_W    = 16;
    localparam int PROD_W   = WEIGHT_W + ACT_W;
    localparam int BIAS_W   = 32;
    localparam int SCALE_W  = 8;
    localparam int ACC_W    = 40;
    localparam int SUM_W    = 64;
    localparam int PART_W   = 16;
    localparam int CFG_W    = 32;
    localparam int ADDR_W   = 3;

    localparam logic [PART_W-1:0] PART_LEN_RST = 16'hFFFF;

    // Register indexes, taken from paddr[2].
    localparam logic REG_PARTITION_LENGTH = 1'b0;
    localparam logic REG_SCALED_MODE      = 1'b1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -64'sh0000_0000_8000_0000;

    // One classified element handed from the front part to the back part.
    typedef struct packed {
        logic [PROD_W-1:0]  product;
        logic [BIAS_W-1:0]  bias;
        logic [SCALE_W-1:0] scale;
        logic               first;
        logic               scaled;
        logic               flush;
        logic               part_end;
        logic               last;
    } sardp_item_t;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_SCALE,
        ST_ADD
    } sardp_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sardp_front.sv
`default_nettype none

module sardp_front
    import sardp_pkg::*;
#(
    parameter int BLOCK_LENGTH = BLOCK_LENGTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                accept,
    input  wire logic [WEIGHT_W-1:0] weight,
    input  wire logic [ACT_W-1:0]    activation,
    input  wire logic [BIAS_W-1:0]   bias,
    input  wire logic [SCALE_W-1:0]  multiplier,
    input  wire logic                last_element,
    input  wire logic [PART_W-1:0]   partition_length,
    input  wire logic                scaled_mode,
    output sardp_item_t              item
);

    localparam int BP_W = $clog2(BLOCK_LENGTH + 1);

    logic [BP_W-1:0]   bp_reg, bp_next;
    logic [PART_W-1:0] pp_reg, pp_next;
    logic              row_active_reg, row_active_next;

    logic              first;
    logic [BP_W-1:0]   bp_inc;
    logic [PART_W-1:0] pp_inc;
    logic              block_full;
    logic              part_end;
    logic signed [PROD_W-1:0] product;

    assign product = $signed(weight) * $signed(activation);

    always_comb begin
        first      = !row_active_reg;
        bp_inc     = (first ? '0 : bp_reg) + BP_W'(scaled_mode);
        pp_inc     = (first ? '0 : pp_reg) + PART_W'(1);
        block_full = scaled_mode && (bp_inc == BP_W'(BLOCK_LENGTH));
        part_end   = (pp_inc == partition_length) || last_element;

        bp_next         = (block_full || part_end) ? '0 : bp_inc;
        pp_next         = part_end ? '0 : pp_inc;
        row_active_next = !last_element;

        item.product  = product;
        item.bias     = bias;
        item.scale    = multiplier;
        item.first    = first;
        item.scaled   = scaled_mode;
        item.flush    = block_full || part_end;
        item.part_end = part_end;
        item.last     = last_element;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bp_reg         <= '0;
            pp_reg         <= '0;
            row_active_reg <= 1'b0;
        end else if (accept) begin
            bp_reg         <= bp_next;
            pp_reg         <= pp_next;
            row_active_reg <= row_active_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sardp_queue.sv
`default_nettype none

module sardp_queue
    import sardp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire sardp_item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output sardp_item_t pop_item,
    output logic       empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sardp_item_t       slots_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slots_reg[rd_ptr_reg];

    always_comb begin
        do_push     = push && !full;
        do_pop      = pop && !empty;
        wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        count_next  = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sardp_back.sv
`default_nettype none

module sardp_back
    import sardp_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire sardp_item_t item,
    input  wire logic   item_valid,
    output logic        item_pop,
    output logic        m_valid,
    input  wire logic   m_ready,
    output logic [31:0] m_row_sum,
    output logic        m_saturated,
    output logic [31:0] m_saturation_total
);

    localparam int MUL_W = ACC_W + SCALE_W + 1;

    sardp_state_t state_reg, state_next;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [MUL_W-1:0] mul_reg, mul_next;
    logic [SCALE_W-1:0]      scale_reg;
    logic                    part_end_reg;
    logic                    last_reg;
    logic                    row_sat_reg, row_sat_next;
    logic [31:0]             sat_count_reg, sat_count_next;
    logic                    out_valid_reg, out_valid_next;
    logic [31:0]             out_sum_reg;
    logic                    out_sat_reg;
    logic [31:0]             out_total_reg;

    logic                    out_free;
    logic                    add_done;
    logic                    load_item;
    logic signed [SUM_W-1:0] prod_sum;
    logic signed [ACC_W-1:0] prod_acc;
    logic signed [SUM_W-1:0] sum_add;
    logic                    over, under;

    assign out_free = !out_valid_reg || m_ready;
    // The last element of a row always ends a partition, so its result is
    // formed in the add step and that step waits for a free output slot.
    assign add_done = !last_reg || out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCUM: begin
                if (item_valid && item.flush) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                state_next = ST_ADD;
            end
            ST_ADD: begin
                if (add_done) begin
                    state_next = ST_ACCUM;
                end
            end
            default: begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_comb begin
        load_item = (state_reg == ST_ACCUM) && item_valid;
        item_pop  = load_item;

        prod_sum = SUM_W'($signed(item.product));
        prod_acc = ACC_W'($signed(item.product));
        sum_add  = sum_reg + SUM_W'(mul_reg);
        over     = sum_add > SUM_MAX;
        under    = sum_add < SUM_MIN;

        sum_next       = sum_reg;
        acc_next       = acc_reg;
        mul_next       = mul_reg;
        row_sat_next   = row_sat_reg;
        sat_count_next = sat_count_reg;
        out_valid_next = out_valid_reg && !m_ready;

        unique case (state_reg)
            ST_ACCUM: begin
                if (load_item) begin
                    if (item.first) begin
                        sum_next     = SUM_W'($signed(item.bias)) + (item.scaled ? '0 : prod_sum);
                        acc_next     = item.scaled ? prod_acc : '0;
                        row_sat_next = 1'b0;
                    end else begin
                        sum_next = sum_reg + (item.scaled ? '0 : prod_sum);
                        acc_next = acc_reg + (item.scaled ? prod_acc : '0);
                    end
                end
            end
            ST_SCALE: begin
                mul_next = acc_reg * $signed({1'b0, scale_reg});
                acc_next = '0;
            end
            ST_ADD: begin
                if (add_done) begin
                    sum_next = sum_add;
                    if (part_end_reg && (over || under)) begin
                        sum_next       = over ? SUM_MAX : SUM_MIN;
                        row_sat_next   = 1'b1;
                        sat_count_next = sat_count_reg + 32'd1;
                    end
                    if (last_reg) begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACCUM;
            sum_reg       <= '0;
            acc_reg       <= '0;
            row_sat_reg   <= 1'b0;
            sat_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            acc_reg       <= acc_next;
            row_sat_reg   <= row_sat_next;
            sat_count_reg <= sat_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mul_reg <= mul_next;
        if (load_item) begin
            scale_reg    <= item.scale;
            part_end_reg <= item.part_end;
            last_reg     <= item.last;
        end
        if ((state_reg == ST_ADD) && add_done && last_reg) begin
            out_sum_reg   <= sum_next[31:0];
            out_sat_reg   <= row_sat_next;
            out_total_reg <= sat_count_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_row_sum          = out_sum_reg;
    assign m_saturated        = out_sat_reg;
    assign m_saturation_total = out_total_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/saturating_affine_row_dot_product.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    weight, activation, bias, multiplier, last_element
// m_        out        m_valid/m_ready    row_sum, saturated, saturation_total
// APB       in         psel/penable       partition_length (0x0), scaled_mode (0x4)
//
// The front part classifies one element per cycle into a short queue while it is not
// full. The back part accumulates each element; one that ends a block or a partition
// then also goes through scale (by the multiplier) and add, saturated at a partition end.
// A result leaves through an output register; the row end waits only if it is full.
// Synchronous active-low reset on aresetn clears all counters and the queue.
`default_nettype none

module saturating_affine_row_dot_product
    import sardp_pkg::*;
#(
    parameter int BLOCK_LENGTH = BLOCK_LENGTH_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [WEIGHT_W-1:0] s_weight,
    input  wire logic [ACT_W-1:0]   s_activation,
    input  wire logic [BIAS_W-1:0]  s_bias,
    input  wire logic [SCALE_W-1:0] s_multiplier,
    input  wire logic               s_last_element,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [31:0]             m_row_sum,
    output logic                    m_saturated,
    output logic [31:0]             m_saturation_total,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [CFG_W-1:0]   pwdata,
    output logic [CFG_W-1:0]        prdata,
    output logic                    pready
);

    logic [PART_W-1:0] part_len_reg;
    logic              scaled_mode_reg;
    logic              cfg_write;
    logic              accept;
    logic              queue_full;
    logic              queue_empty;
    logic              queue_pop;
    sardp_item_t       front_item;
    sardp_item_t       back_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign s_ready   = !queue_full;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_len_reg    <= PART_LEN_RST;
            scaled_mode_reg <= 1'b1;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_PARTITION_LENGTH: part_len_reg    <= pwdata[PART_W-1:0];
                REG_SCALED_MODE:      scaled_mode_reg <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_PARTITION_LENGTH: prdata = CFG_W'(part_len_reg);
            REG_SCALED_MODE:      prdata = CFG_W'(scaled_mode_reg);
            default:              prdata = '0;
        endcase
    end

    sardp_front #(
        .BLOCK_LENGTH(BLOCK_LENGTH)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .weight           (s_weight),
        .activation       (s_activation),
        .bias             (s_bias),
        .multiplier       (s_multiplier),
        .last_element     (s_last_element),
        .partition_length (part_len_reg),
        .scaled_mode      (scaled_mode_reg),
        .item             (front_item)
    );

    sardp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_item  (back_item),
        .empty     (queue_empty)
    );

    sardp_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .item               (back_item),
        .item_valid         (!queue_empty),
        .item_pop           (queue_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_row_sum          (m_row_sum),
        .m_saturated        (m_saturated),
        .m_saturation_total (m_saturation_total)
    );

endmodule

`default_nettype wire
